// ----- rtl/rrts_pkg.sv -----
package rrts_pkg;

   localparam int ARR_BITS = 8;
   localparam int ENTRY_W = 3;
   localparam int CNT_W = 7;     // holds a queue count up to the largest process count
   localparam int QUANT_W = 16;
   localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd4;

   typedef logic [ENTRY_W-1:0] entry_type;
   typedef entry_type [ARR_BITS-1:0] entry_list_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] count_mid;
      logic             load;
      logic             shift;
      logic             rotate;
   } cell_ctl_type;

   // Pack the set arrival bits into a list of indices, lowest index first.
   function automatic entry_list_type compact_arrivals(input logic [ARR_BITS-1:0] arr);
      entry_list_type list;
      logic [ENTRY_W:0] k;
      list = '0;
      k = '0;
      for (int i = 0; i < ARR_BITS; i++) begin
         if (arr[i]) begin
            list[k[ENTRY_W-1:0]] = entry_type'(i);
            k = k + 1'b1;
         end
      end
      return list;
   endfunction

endpackage

// ----- rtl/rrts_cell.sv -----
module rrts_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                    clock,
   input  rrts_pkg::cell_ctl_type   ctl,
   input  rrts_pkg::entry_list_type arr_list,
   input  rrts_pkg::entry_type      head_val,
   input  rrts_pkg::entry_type      nbr_pre,
   output rrts_pkg::entry_type      pre,
   output rrts_pkg::entry_type      next
);
   import rrts_pkg::*;

   entry_type        entry_ff;
   entry_type        entry_in;
   logic [CNT_W-1:0] idx;
   logic [CNT_W-1:0] off;
   logic             is_tail;

   assign idx = CNT_W'(CELL_IDX);
   assign off = idx - ctl.count;
   assign is_tail = (idx + CNT_W'(1)) == ctl.count_mid;

   // Occupied cells keep their entry, free cells take the next packed arrival.
   assign pre = (idx < ctl.count) ? entry_ff : arr_list[off[ENTRY_W-1:0]];

   always_comb begin
      if (ctl.shift) begin
         entry_in = (ctl.rotate && is_tail) ? head_val : nbr_pre;
      end else begin
         entry_in = pre;
      end
   end

   assign next = entry_in;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ----- rtl/round_robin_tick_scheduler_core.sv -----
// Round-robin tick scheduler with a time quantum.
// Input channel: one time tick per transfer, taken when start is high and
// busy is low. req_arrivals marks processes that become ready this tick;
// req_head_done says the running process at the queue head has finished.
// Result channel: rsp_strobe is high for one cycle with rsp_run_valid and
// rsp_run_index, the process to run this tick (index 0 when invalid).
// The receiver cannot stall; every tick produces exactly one result.
// Configuration: csr_write_en loads csr_write_data into the quantum register;
// a new quantum takes effect at the next reload of the tick counter.
// The result is registered and appears in the cycle after the tick is taken.
// Throughput: one tick per cycle; busy stays low. The ready queue is a row of
// cells with the head in cell zero; each tick appends packed arrivals, shifts
// the row by one on a rotate or drop, and loads the result register.
// Reset: queue empty, quantum and tick counter at 4, no result pending.
module round_robin_tick_scheduler_core #(
   parameter int NUM_PROCS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [rrts_pkg::ARR_BITS-1:0]  req_arrivals,
   input  logic                           req_head_done,
   output logic                           rsp_strobe,
   output logic                           rsp_run_valid,
   output logic [rrts_pkg::ENTRY_W-1:0]   rsp_run_index,
   input  logic                           csr_write_en,
   input  logic [rrts_pkg::QUANT_W-1:0]   csr_write_data
);
   import rrts_pkg::*;

   localparam int CW = $clog2(NUM_PROCS + 1);
   localparam int SW = CW + 4;

   logic [CW-1:0]      count_ff, count_in;
   logic [QUANT_W-1:0] quantum_ff;
   logic [QUANT_W-1:0] ticks_ff, ticks_in;
   logic               strobe_ff;
   logic               run_valid_ff, run_valid_in;
   entry_type          run_index_ff, run_index_in;

   logic [ARR_BITS-1:0] arr_mask;
   logic [ARR_BITS-1:0] arr_used;
   entry_list_type      arr_list;
   logic [SW-1:0]       sum;
   logic [CW-1:0]       count_mid;
   logic [QUANT_W-1:0]  ticks_mid;
   logic                accept;
   logic                reload;
   logic                pop;
   cell_ctl_type        ctl;
   entry_type           pre_w  [NUM_PROCS];
   entry_type           next_w [NUM_PROCS];

   assign busy = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      for (int i = 0; i < ARR_BITS; i++) begin
         arr_mask[i] = (i < NUM_PROCS);
      end
   end

   assign arr_used = req_arrivals & arr_mask;
   assign arr_list = compact_arrivals(arr_used);
   assign sum = SW'(count_ff) + SW'($countones(arr_used));
   assign count_mid = (sum > SW'(NUM_PROCS)) ? CW'(NUM_PROCS) : sum[CW-1:0];

   assign reload = (ticks_ff == '0) || ((count_mid != '0) && req_head_done);
   assign pop = reload && (count_mid != '0);

   always_comb begin
      count_in = (pop && req_head_done) ? count_mid - CW'(1) : count_mid;
      ticks_mid = reload ? quantum_ff : ticks_ff;
      if (count_in != '0) begin
         run_valid_in = 1'b1;
         run_index_in = next_w[0];
         ticks_in = (ticks_mid != '0) ? ticks_mid - QUANT_W'(1) : '0;
      end else begin
         run_valid_in = 1'b0;
         run_index_in = '0;
         ticks_in = '0;
      end
   end

   assign ctl.count = CNT_W'(count_ff);
   assign ctl.count_mid = CNT_W'(count_mid);
   assign ctl.load = accept;
   assign ctl.shift = pop;
   assign ctl.rotate = pop && !req_head_done;

   for (genvar j = 0; j < NUM_PROCS; j++) begin : g_cell
      entry_type nbr;
      if (j == NUM_PROCS - 1) begin : g_last
         assign nbr = pre_w[0];
      end else begin : g_mid
         assign nbr = pre_w[j+1];
      end
      rrts_cell #(
         .CELL_IDX(j)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .arr_list (arr_list),
         .head_val (pre_w[0]),
         .nbr_pre  (nbr),
         .pre      (pre_w[j]),
         .next     (next_w[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         quantum_ff <= QUANTUM_RESET;
         ticks_ff <= QUANTUM_RESET;
         strobe_ff <= 1'b0;
         run_valid_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (csr_write_en) begin
            quantum_ff <= csr_write_data;
         end
         if (accept) begin
            count_ff <= count_in;
            ticks_ff <= ticks_in;
            run_valid_ff <= run_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         run_index_ff <= run_index_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_run_valid = run_valid_ff;
   assign rsp_run_index = run_index_ff;

endmodule

// ----- rtl/rrts_checker.sv -----
module rrts_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [rrts_pkg::ARR_BITS-1:0] req_arrivals,
   input logic                          req_head_done,
   input logic                          rsp_strobe,
   input logic                          rsp_run_valid,
   input logic [rrts_pkg::ENTRY_W-1:0]  rsp_run_index
);
   import rrts_pkg::*;

   // Every transfer in gives exactly one result on the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("tick without result");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result without tick");

   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_run_valid) |-> (rsp_run_index == '0))
      else $error("nonzero index on invalid result");

   // Empty queue stays empty without arrivals.
   a_stay_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_run_valid && start && !busy && req_arrivals == '0)
      |=> !rsp_run_valid)
      else $error("process scheduled from empty queue");

   // A lone arrival of process zero on an empty queue runs at once.
   a_lone_arrival: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_run_valid && start && !busy &&
       req_arrivals == ARR_BITS'(1) && !req_head_done)
      |=> (rsp_run_valid && rsp_run_index == '0))
      else $error("lone arrival not scheduled");

endmodule

bind round_robin_tick_scheduler_core rrts_checker u_rrts_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_arrivals  (req_arrivals),
   .req_head_done (req_head_done),
   .rsp_strobe    (rsp_strobe),
   .rsp_run_valid (rsp_run_valid),
   .rsp_run_index (rsp_run_index)
);

// ----- verif/rrts_run_check_pkg.sv -----
package rrts_run_check_pkg;
   import rrts_pkg::*;

   localparam int NUM_SLOTS = 8;

   typedef struct packed {
      logic      run_valid;
      entry_type run_index;
   } run_slot_type;

   class run_schedule_board;
      logic [QUANT_W-1:0] quantum;
      logic [QUANT_W-1:0] ticks_left;
      entry_type          ready_slots [NUM_SLOTS];
      logic [2:0]         front;
      int                 queued;
      run_slot_type       expected_runs [$];
      int                 error_count;

      function new();
         quantum = QUANTUM_RESET;
         ticks_left = QUANTUM_RESET;
         front = '0;
         queued = 0;
         error_count = 0;
         foreach (ready_slots[i]) ready_slots[i] = '0;
      endfunction

      // Advance the ready queue by one tick and queue up the process it picks.
      function void note_tick(logic [ARR_BITS-1:0] arrivals, logic head_done);
         run_slot_type run;
         logic [2:0]   tail;
         entry_type    leaving;
         for (int i = 0; i < ARR_BITS; i++) begin
            // drop arrivals that find the queue full
            if (arrivals[i] && queued < NUM_SLOTS) begin
               tail = front + 3'(queued);
               ready_slots[tail] = entry_type'(i);
               queued++;
            end
         end
         if (ticks_left == 0 || (queued > 0 && head_done)) begin
            if (queued > 0) begin
               leaving = ready_slots[front];
               if (!head_done) begin
                  tail = front + 3'(queued);
                  ready_slots[tail] = leaving;
               end else begin
                  queued--;
               end
               front = front + 3'd1;
            end
            ticks_left = quantum;
         end
         if (queued > 0) begin
            run.run_valid = 1'b1;
            run.run_index = ready_slots[front];
            if (ticks_left != 0) ticks_left--;
         end else begin
            run = '0;
            ticks_left = '0;
         end
         expected_runs.insert(expected_runs.size(), run);
      endfunction

      function void check_run(logic run_valid, entry_type run_index, realtime stamp);
         run_slot_type want;
         if (expected_runs.size() == 0) begin
            $display("%0.1f ns: result with nothing expected, valid=%0b index=%0d",
                     stamp, run_valid, run_index);
            error_count++;
            return;
         end
         want = expected_runs[0];
         expected_runs.delete(0);
         if (run_valid !== want.run_valid) begin
            $display("%0.1f ns: run_valid expected %0b actual %0b",
                     stamp, want.run_valid, run_valid);
            error_count++;
         end
         if (run_index !== want.run_index) begin
            $display("%0.1f ns: run_index expected %0d actual %0d",
                     stamp, want.run_index, run_index);
            error_count++;
         end
      endfunction
   endclass

endpackage

// ----- verif/round_robin_tick_scheduler_core_tb.sv -----
module round_robin_tick_scheduler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rrts_pkg::*;
   import rrts_run_check_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_TICKS = 130;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ARR_BITS-1:0] req_arrivals = '0;
   logic                req_head_done = 1'b0;
   logic                rsp_strobe;
   logic                rsp_run_valid;
   logic [ENTRY_W-1:0]  rsp_run_index;
   logic                csr_write_en = 1'b0;
   logic [QUANT_W-1:0]  csr_write_data = '0;

   run_schedule_board board;
   int                quiet_cycles = 0;

   round_robin_tick_scheduler_core #(
      .NUM_PROCS(8)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_arrivals   (req_arrivals),
      .req_head_done  (req_head_done),
      .rsp_strobe     (rsp_strobe),
      .rsp_run_valid  (rsp_run_valid),
      .rsp_run_index  (rsp_run_index),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #2 clock = ~clock;

   // Check the previous tick's result before noting the tick taken at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) board.check_run(rsp_run_valid, rsp_run_index, $realtime);
         if (start && !busy) board.note_tick(req_arrivals, req_head_done);
         if (csr_write_en) board.quantum = csr_write_data;
         if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("round_robin_tick_scheduler_core_tb: errors");
         $finish;
      end
   end

   // Hold start high across back-to-back transfers; callers lower it via hold_off or wait_drained.
   task automatic send_tick(input logic [ARR_BITS-1:0] arrivals, input logic head_done);
      start <= 1'b1;
      req_arrivals <= arrivals;
      req_head_done <= head_done;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      req_arrivals <= ARR_BITS'($urandom);
      req_head_done <= 1'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (board.expected_runs.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [QUANT_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   task automatic run_phase(input int ticks, input bit with_gaps);
      int                  done_pct;
      int                  sel;
      int                  gap;
      logic [ARR_BITS-1:0] arrivals;
      done_pct = $urandom_range(5, 60);
      for (int n = 0; n < ticks; n++) begin
         sel = $urandom_range(0, 19);
         if (sel < 9) arrivals = '0;
         else if (sel < 15) arrivals = ARR_BITS'(1) << $urandom_range(0, ARR_BITS - 1);
         else if (sel < 18) arrivals = ARR_BITS'($urandom);
         else arrivals = '1;
         send_tick(arrivals, $urandom_range(0, 99) < done_pct);
         if (with_gaps) begin
            gap = pick_gap();
            if (gap > 0) hold_off(gap);
         end
         if ($urandom_range(0, 149) == 0) wait_drained();
      end
   endtask

   initial begin
      logic [QUANT_W-1:0] phase_quantum [6];
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue ignores done, then a repeated arrival and quantum expiry
      send_tick(8'h00, 1'b1);
      send_tick(8'h01, 1'b0);
      send_tick(8'h01, 1'b0);
      repeat (4) send_tick(8'h00, 1'b0);
      // fill the queue, then overflow it
      send_tick(8'hFF, 1'b0);
      send_tick(8'hFF, 1'b0);
      repeat (3) send_tick(8'h00, 1'b1);
      send_tick(8'h80, 1'b1);
      repeat (3) send_tick(8'h00, 1'b0);
      wait_drained();

      write_quantum(16'd1);
      send_tick(8'h0A, 1'b0);
      send_tick(8'h00, 1'b0);
      send_tick(8'h00, 1'b1);
      send_tick(8'h00, 1'b1);
      send_tick(8'h00, 1'b0);
      wait_drained();

      // zero quantum behaves like one
      write_quantum(16'd0);
      send_tick(8'h05, 1'b0);
      send_tick(8'h00, 1'b0);
      send_tick(8'h00, 1'b0);
      wait_drained();

      phase_quantum[0] = 16'd2;
      phase_quantum[1] = 16'hFFFF;
      phase_quantum[2] = 16'd1;
      phase_quantum[3] = QUANT_W'($urandom_range(3, 65534));
      phase_quantum[4] = 16'd0;
      phase_quantum[5] = QUANT_W'($urandom_range(3, 12));
      foreach (phase_quantum[p]) begin
         write_quantum(phase_quantum[p]);
         run_phase(PHASE_TICKS, p != 2);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (board.error_count == 0 && board.expected_runs.size() == 0) begin
         $display("round_robin_tick_scheduler_core_tb: clean");
      end else begin
         $display("round_robin_tick_scheduler_core_tb: errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/rrts_pkg.sv
rtl/rrts_cell.sv
rtl/round_robin_tick_scheduler_core.sv
rtl/rrts_checker.sv
verif/rrts_run_check_pkg.sv
verif/round_robin_tick_scheduler_core_tb.sv
